@@ rtl/sed_pkg.sv @@
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants for the Sobel edge magnitude block
// Pixel and window column types, configuration register indexes, reset
// values and field widths used by the datapath, line stores and window cells.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;   // frame_width register
  localparam int FH_W       = 12;   // frame_height register
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CROW_W     = 12;
  localparam int CCOL_W     = 10;
  localparam int SUM_W      = 10;   // a + 2b + c of three pixels
  localparam int MAG_W      = 11;   // sum of two absolute differences
  localparam int CMP_W      = 13;   // holds any width up to 4096
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [FH_W-1:0] MIN_DIM          = 12'd3;
  localparam logic [PIX_W-1:0] MAG_MAX         = 8'd255;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

endpackage

@@ rtl/sed_col_cell.sv @@
// ----------------------------------------------------------------------------
// sed_col_cell: one window column cell
// Holds one 3-pixel column of the 3x3 window and hands it to the next cell
// each time the window advances.
// ----------------------------------------------------------------------------
module sed_col_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  sed_pkg::col_t col_in,
  output sed_pkg::col_t col_out
);

  sed_pkg::col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

@@ rtl/sed_line_store.sv @@
// ----------------------------------------------------------------------------
// sed_line_store: single-port-write, registered-read line memory
// One image row of pixels; read data is registered and held when no read.
// ----------------------------------------------------------------------------
module sed_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  sed_pkg::pix_t      wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output sed_pkg::pix_t      rd_data
);

  sed_pkg::pix_t mem [DEPTH];
  sed_pkg::pix_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/sobel_edge_magnitude.sv @@
// Path: stage 1 (pixel, line store reads), stage 2 (sums), output register.
// Throughput: one pixel per cycle unless out_tready stalls; set by the single
// read per cycle of each line store and the window cell chain advancing once per pixel.
// Reset (rst_n low, synchronous) clears the counters, pipeline valids and
// window cells and loads frame_width 640, frame_height 480; line stores are
// not cleared and hold no meaning until written.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude: streaming 3x3 Sobel edge detector, L1 magnitude
// Raster-order grey pixels in, one saturated magnitude with centre
// coordinates out for every interior pixel of the frame.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: [7:0] grey_pixel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [sed_pkg::IN_TDATA_W-1:0]        in_tdata,
  // out_tdata: [7:0] edge_magnitude, [19:8] centre_row, [29:20] centre_col,
  //            [31:30] zero; out_tlast: frame_done
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [sed_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sed_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sed_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = sed_pkg::CMP_W;

  // configuration
  logic [sed_pkg::FW_W-1:0] frame_width_r;
  logic [sed_pkg::FH_W-1:0] frame_height_r;
  logic [EW-1:0]            eff_w;
  logic [sed_pkg::FH_W-1:0] eff_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= sed_pkg::FRAME_WIDTH_RST;
      frame_height_r <= sed_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sed_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[sed_pkg::FW_W-1:0];
        sed_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = EW'(frame_width_r);
    if (eff_w < EW'(sed_pkg::MIN_DIM)) begin
      eff_w = EW'(sed_pkg::MIN_DIM);
    end else if (eff_w > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end
    eff_h = (frame_height_r < sed_pkg::MIN_DIM) ? sed_pkg::MIN_DIM : frame_height_r;
  end

  // handshake: each stage advances when it is empty or the next one moves
  logic out_valid_r, s2_valid_r, s1_valid_r;
  logic out_adv, s2_adv, s1_adv, in_acc, s1_fire;

  assign out_adv   = !out_valid_r || out_tready;
  assign s2_adv    = !s2_valid_r || out_adv;
  assign s1_adv    = !s1_valid_r || s2_adv;
  assign in_tready = s1_adv;
  assign in_acc    = in_tvalid && s1_adv;
  assign s1_fire   = s1_valid_r && s2_adv;

  // position counters
  logic [CW-1:0]             col_r;
  logic [sed_pkg::CROW_W-1:0] row_r;
  logic                       last_col, last_row, interior;
  logic [CW-1:0]              col_m1;

  assign last_col = EW'(col_r) >= (eff_w - EW'(1));
  assign last_row = row_r >= (eff_h - sed_pkg::CROW_W'(1));
  assign interior = (row_r >= sed_pkg::CROW_W'(2)) && (col_r >= CW'(2));
  assign col_m1   = col_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + sed_pkg::CROW_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // stage 1: pixel with line store reads in flight
  sed_pkg::pix_t              s1_pix_r;
  logic [CW-1:0]              s1_idx_r;
  logic                       s1_int_r, s1_last_r;
  logic [sed_pkg::CROW_W-1:0] s1_crow_r;
  logic [sed_pkg::CCOL_W-1:0] s1_ccol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_tdata[sed_pkg::PIX_W-1:0];
      s1_idx_r  <= col_r;
      s1_int_r  <= interior;
      s1_last_r <= last_col && last_row;
      s1_crow_r <= row_r - sed_pkg::CROW_W'(1);
      s1_ccol_r <= sed_pkg::CCOL_W'(col_m1);
    end
  end

  sed_pkg::pix_t upper_rd, middle_rd;

  // upper row takes what the middle row held; middle takes the new pixel
  sed_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_idx_r),
    .wr_data (middle_rd),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (upper_rd)
  );

  sed_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_middle (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_idx_r),
    .wr_data (s1_pix_r),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (middle_rd)
  );

  // window: cell 0 holds the previous column, cell 1 the one before it
  sed_pkg::col_t new_col, col_b, col_a;

  assign new_col = '{top: upper_rd, mid: middle_rd, bot: s1_pix_r};

  sed_col_cell u_cell0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_fire),
    .col_in   (new_col),
    .col_out  (col_b)
  );

  sed_col_cell u_cell1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_fire),
    .col_in   (col_b),
    .col_out  (col_a)
  );

  logic [sed_pkg::SUM_W-1:0] top_sum, bot_sum, left_sum, right_sum;

  assign top_sum   = sed_pkg::SUM_W'(col_a.top) + {1'b0, col_b.top, 1'b0}
                   + sed_pkg::SUM_W'(new_col.top);
  assign bot_sum   = sed_pkg::SUM_W'(col_a.bot) + {1'b0, col_b.bot, 1'b0}
                   + sed_pkg::SUM_W'(new_col.bot);
  assign left_sum  = sed_pkg::SUM_W'(col_a.top) + {1'b0, col_a.mid, 1'b0}
                   + sed_pkg::SUM_W'(col_a.bot);
  assign right_sum = sed_pkg::SUM_W'(new_col.top) + {1'b0, new_col.mid, 1'b0}
                   + sed_pkg::SUM_W'(new_col.bot);

  // stage 2: registered sums, border items dropped
  logic [sed_pkg::SUM_W-1:0]  s2_top_r, s2_bot_r, s2_left_r, s2_right_r;
  logic                       s2_last_r;
  logic [sed_pkg::CROW_W-1:0] s2_crow_r;
  logic [sed_pkg::CCOL_W-1:0] s2_ccol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r && s1_int_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_top_r   <= top_sum;
      s2_bot_r   <= bot_sum;
      s2_left_r  <= left_sum;
      s2_right_r <= right_sum;
      s2_last_r  <= s1_last_r;
      s2_crow_r  <= s1_crow_r;
      s2_ccol_r  <= s1_ccol_r;
    end
  end

  logic [sed_pkg::SUM_W-1:0] row_diff, col_diff;
  logic [sed_pkg::MAG_W-1:0] mag_sum;
  sed_pkg::pix_t             mag_sat;

  assign row_diff = (s2_top_r > s2_bot_r) ? s2_top_r - s2_bot_r : s2_bot_r - s2_top_r;
  assign col_diff = (s2_left_r > s2_right_r) ? s2_left_r - s2_right_r
                                             : s2_right_r - s2_left_r;
  assign mag_sum  = sed_pkg::MAG_W'(row_diff) + sed_pkg::MAG_W'(col_diff);
  assign mag_sat  = (mag_sum > sed_pkg::MAG_W'(sed_pkg::MAG_MAX)) ? sed_pkg::MAG_MAX
                                                                  : mag_sum[7:0];

  // output register
  sed_pkg::pix_t              out_mag_r;
  logic                       out_last_r;
  logic [sed_pkg::CROW_W-1:0] out_crow_r;
  logic [sed_pkg::CCOL_W-1:0] out_ccol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_valid_r) begin
      out_mag_r  <= mag_sat;
      out_last_r <= s2_last_r;
      out_crow_r <= s2_crow_r;
      out_ccol_r <= s2_ccol_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_ccol_r, out_crow_r, out_mag_r};

endmodule

@@ rtl/sed_checker.sv @@
// ----------------------------------------------------------------------------
// sed_checker: port-level checks for the Sobel edge magnitude block
// Watches the result channel for reset behavior, pipeline fill, stall hold and payload.
// ----------------------------------------------------------------------------
module sed_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sed_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              out_tlast
);

  // reset empties the result channel
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // three pipeline stages must fill before the first result
  a_fill_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid ##1 !out_tvalid ##1 !out_tvalid)
    else $error("result appeared before the pipeline could fill");

  // stalled transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // interior centre row is never zero and padding stays clear
  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:30] == 2'b00) && (out_tdata[19:8] != 12'd0))
    else $error("bad result payload");

endmodule

bind sobel_edge_magnitude sed_checker u_sed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
